// ===== sv/ulr_pkg.sv =====
// Package for the UTF-8 lossy repair unit: transfer payload types, the
// burst record passed from the decoder to the output stage, and byte constants.
// No dependencies.
`default_nettype none

package ulr_pkg;

    // Most result bytes one input byte can cause (two replacement characters).
    localparam int MaxResults = 6;

    // Replacement character U+FFFD in UTF-8 form, and its byte count.
    localparam logic [23:0] ReplBytes = 24'hEFBFBD;
    localparam logic [2:0]  ReplLen   = 3'd3;

    // Lead byte ranges.
    localparam logic [7:0] AsciiTop   = 8'h7F;
    localparam logic [7:0] Lead2Lo    = 8'hC2;
    localparam logic [7:0] Lead2Hi    = 8'hDF;
    localparam logic [7:0] Lead3Lo    = 8'hE0;
    localparam logic [7:0] Lead3Hi    = 8'hEF;
    localparam logic [7:0] Lead4Lo    = 8'hF0;
    localparam logic [7:0] Lead4Hi    = 8'hF4;

    // Leads that narrow the bounds of the second byte.
    localparam logic [7:0] LeadE0     = 8'hE0;
    localparam logic [7:0] LeadED     = 8'hED;
    localparam logic [7:0] LeadF0     = 8'hF0;
    localparam logic [7:0] LeadF4     = 8'hF4;

    // Continuation byte bounds, plain and narrowed.
    localparam logic [7:0] ContLo     = 8'h80;
    localparam logic [7:0] ContHi     = 8'hBF;
    localparam logic [7:0] ContLoE0   = 8'hA0;
    localparam logic [7:0] ContHiED   = 8'h9F;
    localparam logic [7:0] ContLoF0   = 8'h90;
    localparam logic [7:0] ContHiF4   = 8'h8F;

    // Input transfer payload.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } ulr_in_t;

    // Result transfer payload.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } ulr_out_t;

    // Bytes caused by one input; the first byte sits at index count-1.
    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [2:0]                 count;
    } ulr_burst_t;

endpackage

`default_nettype wire

// ===== sv/ulr_decode.sv =====
// Decoder of the UTF-8 lossy repair unit: pending-sequence state and the
// single-pass logic that turns one input byte into a burst of result bytes.
// Depends on ulr_pkg.
`default_nettype none

module ulr_decode (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                advance,
    input  wire ulr_pkg::ulr_in_t    in_data,
    output ulr_pkg::ulr_burst_t      burst
);

    // Pending sequence state.
    logic [2:0][7:0] held_bytes_reg;
    logic [2:0][7:0] held_bytes_next;
    logic [1:0]      held_count_reg;
    logic [1:0]      held_count_next;
    logic [2:0]      seq_length_reg;
    logic [2:0]      seq_length_next;

    // Sequence length announced by a lead byte, zero for a byte that is no lead.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b >= ulr_pkg::Lead2Lo && b <= ulr_pkg::Lead2Hi) begin
            len = 3'd2;
        end else if (b >= ulr_pkg::Lead3Lo && b <= ulr_pkg::Lead3Hi) begin
            len = 3'd3;
        end else if (b >= ulr_pkg::Lead4Lo && b <= ulr_pkg::Lead4Hi) begin
            len = 3'd4;
        end
        return len;
    endfunction

    // Whether a byte may continue a sequence at the given position.
    function automatic logic fits(input logic [7:0] lead, input logic [1:0] pos,
                                  input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = ulr_pkg::ContLo;
        hi = ulr_pkg::ContHi;
        if (pos == 2'd1) begin
            if (lead == ulr_pkg::LeadE0) lo = ulr_pkg::ContLoE0;
            if (lead == ulr_pkg::LeadED) hi = ulr_pkg::ContHiED;
            if (lead == ulr_pkg::LeadF0) lo = ulr_pkg::ContLoF0;
            if (lead == ulr_pkg::LeadF4) hi = ulr_pkg::ContHiF4;
        end
        return (b >= lo) && (b <= hi);
    endfunction

    // Build the burst by shifting bytes in at the low end, so the first byte
    // ends up highest; the state update follows the same decisions.
    always_comb begin
        logic [8*ulr_pkg::MaxResults-1:0] acc;
        logic [2:0]                       n;
        logic                             fresh;
        logic [7:0]                       b;
        logic [2:0]                       len;

        acc             = '0;
        n               = 3'd0;
        fresh           = 1'b0;
        b               = in_data.in_byte;
        len             = lead_len(b);
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        seq_length_next = seq_length_reg;

        if (held_count_reg == 2'd0) begin
            fresh = 1'b1;
        end else if (fits(held_bytes_reg[0], held_count_reg, b)) begin
            if ({1'b0, held_count_reg} + 3'd1 >= seq_length_reg) begin
                // Sequence complete: pass the held bytes and this one through.
                for (int k = 0; k < 3; k++) begin
                    if (2'(k) < held_count_reg) begin
                        acc = {acc[8*ulr_pkg::MaxResults-9:0], held_bytes_reg[k]};
                        n   = n + 3'd1;
                    end
                end
                acc             = {acc[8*ulr_pkg::MaxResults-9:0], b};
                n               = n + 3'd1;
                held_count_next = 2'd0;
                seq_length_next = 3'd0;
            end else begin
                held_bytes_next[held_count_reg] = b;
                held_count_next                 = held_count_reg + 2'd1;
            end
        end else begin
            // Broken sequence: replace it and handle this byte afresh.
            acc             = {acc[8*ulr_pkg::MaxResults-25:0], ulr_pkg::ReplBytes};
            n               = n + ulr_pkg::ReplLen;
            held_count_next = 2'd0;
            seq_length_next = 3'd0;
            fresh           = 1'b1;
        end

        // A byte seen with nothing pending.
        if (fresh) begin
            if (b <= ulr_pkg::AsciiTop) begin
                acc = {acc[8*ulr_pkg::MaxResults-9:0], b};
                n   = n + 3'd1;
            end else if (len != 3'd0) begin
                held_bytes_next[0] = b;
                held_count_next    = 2'd1;
                seq_length_next    = len;
            end else begin
                acc = {acc[8*ulr_pkg::MaxResults-25:0], ulr_pkg::ReplBytes};
                n   = n + ulr_pkg::ReplLen;
            end
        end

        // End of text flushes whatever is still pending.
        if (in_data.end_of_text && held_count_next != 2'd0) begin
            acc             = {acc[8*ulr_pkg::MaxResults-25:0], ulr_pkg::ReplBytes};
            n               = n + ulr_pkg::ReplLen;
            held_count_next = 2'd0;
            seq_length_next = 3'd0;
        end

        burst.bytes = acc;
        burst.count = n;
    end

    // State advances once per input item handed to the output stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_bytes_reg <= '0;
            held_count_reg <= 2'd0;
            seq_length_reg <= 3'd0;
        end else if (advance) begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
            seq_length_reg <= seq_length_next;
        end
    end

`ifndef SYNTHESIS
    // A pending sequence is always shorter than its announced length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg != 2'd0 |-> {1'b0, held_count_reg} < seq_length_reg)
        else $error("pending byte count reached the sequence length");

    // With nothing pending no sequence length is kept.
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg == 2'd0 |-> seq_length_reg == 3'd0)
        else $error("sequence length kept with nothing pending");
`endif

endmodule

`default_nettype wire

// ===== sv/ulr_burst.sv =====
// Output stage of the UTF-8 lossy repair unit: holds one burst of result
// bytes and sends them one transfer at a time. Depends on ulr_pkg.
`default_nettype none

module ulr_burst (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire ulr_pkg::ulr_burst_t burst,
    output logic                     burst_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ulr_pkg::ulr_out_t        m_data
);

    logic [ulr_pkg::MaxResults-1:0][7:0] bytes_reg;
    logic [2:0]                          rem_reg;

    // The stage can take a new burst when empty or when its last byte leaves now.
    assign burst_ready = (rem_reg == 3'd0) || (rem_reg == 3'd1 && m_ready);

    // Send the highest remaining byte first.
    assign m_valid            = rem_reg != 3'd0;
    assign m_data.out_byte    = bytes_reg[rem_reg - 3'd1];
    assign m_data.last_of_run = rem_reg == 3'd1;

    // Burst register and remaining count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 3'd0;
        end else if (load) begin
            rem_reg <= burst.count;
        end else if (m_valid && m_ready) begin
            rem_reg <= rem_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= burst.bytes;
        end
    end

`ifndef SYNTHESIS
    // No burst holds more bytes than one input can cause.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= 3'(ulr_pkg::MaxResults))
        else $error("burst count out of range");

    // A new burst never overwrites bytes that are still to be sent.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> rem_reg == 3'd0 || (rem_reg == 3'd1 && m_ready))
        else $error("burst loaded over unsent bytes");
`endif

endmodule

`default_nettype wire

// ===== sv/utf8_lossy_repair_unit.sv =====
// Top level of the UTF-8 lossy repair unit: input register, decoder and
// output stage. Depends on ulr_pkg, ulr_decode and ulr_burst.
//
//   Channel   Ports                      Carries
//   input     s_valid s_ready s_data     one raw byte plus end-of-text mark
//   result    m_valid m_ready m_data     one repaired byte plus last-of-run mark
//
// An input byte is registered, decoded in one pass and moved into the output
// burst register once the output stage can take its burst; it is followed by
// 0 to 6 result transfers. The output stage sends one byte per cycle while
// m_ready is high; with at most one result each and no stall, one input is
// taken every cycle. Reset clears the pending sequence and both stages.
// A stalled result channel holds the burst and backs up into s_ready.
`default_nettype none

module utf8_lossy_repair_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ulr_pkg::ulr_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ulr_pkg::ulr_out_t      m_data
);

    logic                in_valid_reg;
    ulr_pkg::ulr_in_t    in_data_reg;
    logic                burst_ready;
    logic                advance;
    ulr_pkg::ulr_burst_t burst;

    // The registered item moves on when the output stage can take its burst.
    assign advance = in_valid_reg && burst_ready;
    assign s_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Decoder with the pending-sequence state.
    ulr_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_data (in_data_reg),
        .burst   (burst)
    );

    // Output burst stage.
    ulr_burst u_burst (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance),
        .burst       (burst),
        .burst_ready (burst_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

`default_nettype wire

// ===== tb/tb_utf8_lossy_repair_unit.sv =====
// Self-checking testbench for utf8_lossy_repair_unit: drives raw bytes, predicts the
// repaired UTF-8 stream with a scoreboard class, and checks every result transfer.
// Depends on ulr_pkg and utf8_lossy_repair_unit.
`default_nettype none

module tb_utf8_lossy_repair_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 200_000;
    localparam int unsigned RandomItems = 145;
    localparam int unsigned HoldOffCycles = 90;
    localparam int unsigned MaxPrinted = 40;

    // Directed bytes; bit 8 carries the end-of-text mark.
    localparam logic [8:0] DirectedSeq [25] = '{
        9'h000, 9'h07F, 9'h080, 9'h0C1, 9'h0F5, 9'h0FF,
        9'h0C2, 9'h080,
        9'h0E0, 9'h0A0, 9'h0BF,
        9'h0E0, 9'h080,
        9'h0ED, 9'h0A0,
        9'h0F0, 9'h090, 9'h080, 9'h0BF,
        9'h0F4, 9'h090,
        9'h141,
        9'h0F4, 9'h18F,
        9'h1DF
    };

    // Predicts the repaired byte stream and checks result transfers against it.
    class repair_scoreboard;
        ulr_pkg::ulr_out_t expected_q[$];
        logic [7:0]        run_bytes[$];
        logic [7:0]        held[3];
        int unsigned       held_cnt;
        int unsigned       seq_len;
        int unsigned       errors;
        int unsigned       results_seen;
        int unsigned       repl_chars;

        function new();
            held_cnt = 0;
            seq_len = 0;
            errors = 0;
            results_seen = 0;
            repl_chars = 0;
            foreach (held[i]) held[i] = '0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Appends one byte to the run caused by the current input.
        function void add_run_byte(logic [7:0] v);
            run_bytes.insert(run_bytes.size(), v);
        endfunction

        function void emit_fffd();
            repl_chars++;
            add_run_byte(ulr_pkg::ReplBytes[23:16]);
            add_run_byte(ulr_pkg::ReplBytes[15:8]);
            add_run_byte(ulr_pkg::ReplBytes[7:0]);
        endfunction

        // A byte seen with nothing pending: ASCII passes, a lead is held, else U+FFFD.
        function void start_fresh(logic [7:0] b);
            int unsigned len;
            len = 0;
            if (b >= ulr_pkg::Lead2Lo && b <= ulr_pkg::Lead2Hi) len = 2;
            else if (b >= ulr_pkg::Lead3Lo && b <= ulr_pkg::Lead3Hi) len = 3;
            else if (b >= ulr_pkg::Lead4Lo && b <= ulr_pkg::Lead4Hi) len = 4;
            if (b <= ulr_pkg::AsciiTop) begin
                add_run_byte(b);
            end else if (len != 0) begin
                held[0] = b;
                held_cnt = 1;
                seq_len = len;
            end else begin
                emit_fffd();
            end
        endfunction

        // Works out the result transfers caused by one accepted input transfer.
        function void note_input(ulr_pkg::ulr_in_t d);
            logic [7:0]        b;
            logic [7:0]        lo;
            logic [7:0]        hi;
            ulr_pkg::ulr_out_t r;
            b = d.in_byte;
            run_bytes.delete();
            if (held_cnt == 0) begin
                start_fresh(b);
            end else begin
                lo = ulr_pkg::ContLo;
                hi = ulr_pkg::ContHi;
                // Only the second byte has narrowed bounds.
                if (held_cnt == 1) begin
                    if (held[0] == ulr_pkg::LeadE0) lo = ulr_pkg::ContLoE0;
                    if (held[0] == ulr_pkg::LeadED) hi = ulr_pkg::ContHiED;
                    if (held[0] == ulr_pkg::LeadF0) lo = ulr_pkg::ContLoF0;
                    if (held[0] == ulr_pkg::LeadF4) hi = ulr_pkg::ContHiF4;
                end
                if (b >= lo && b <= hi) begin
                    if (held_cnt + 1 >= seq_len) begin
                        for (int unsigned k = 0; k < held_cnt; k++) add_run_byte(held[k]);
                        add_run_byte(b);
                        held_cnt = 0;
                        seq_len = 0;
                    end else begin
                        held[held_cnt] = b;
                        held_cnt++;
                    end
                end else begin
                    // The broken subpart is replaced, then the byte is taken afresh.
                    emit_fffd();
                    held_cnt = 0;
                    seq_len = 0;
                    start_fresh(b);
                end
            end
            if (d.end_of_text && held_cnt != 0) begin
                emit_fffd();
                held_cnt = 0;
                seq_len = 0;
            end
            foreach (run_bytes[i]) begin
                r.out_byte = run_bytes[i];
                r.last_of_run = (i == run_bytes.size() - 1);
                expected_q.insert(expected_q.size(), r);
            end
        endfunction

        // Prints one line per mismatch (up to a cap) and counts all of them.
        task report(string msg);
            if (errors < MaxPrinted) $display("ERROR at result %0d: %s", results_seen, msg);
            errors++;
        endtask

        task check_result(ulr_pkg::ulr_out_t got);
            ulr_pkg::ulr_out_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected byte %02h, nothing expected", got.out_byte));
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %02h, expected %02h", got.out_byte, want.out_byte));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run %0b, expected %0b",
                                 got.last_of_run, want.last_of_run));
        endtask
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    ulr_pkg::ulr_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    ulr_pkg::ulr_out_t m_data;

    repair_scoreboard sb = new();

    int unsigned cycles = 0;
    int unsigned burst_left = 0;
    int unsigned hold_req = 0;
    int unsigned stall_left = 0;
    int unsigned longest_hold = 0;
    int unsigned backpressure_cycles = 0;
    int unsigned directed_n = 0;
    int unsigned random_n = 0;

    utf8_lossy_repair_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock with a 2 ns period.
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, sb.pending());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result monitor: every accepted result transfer is checked.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if (aresetn && s_valid && !s_ready) backpressure_cycles++;
    end

    // Receiver: a stall pattern chosen anew at random, plus requested hold-offs.
    initial begin
        int unsigned rcyc;
        int unsigned mode;
        rcyc = 0;
        mode = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                stall_left = hold_req;
                if (hold_req > longest_hold) longest_hold = hold_req;
                hold_req = 0;
            end
            if (rcyc % 64 == 0) mode = $urandom_range(0, 3);
            rcyc++;
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    2: m_ready <= ((rcyc % 7) < 4);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offers one input transfer and waits for it to be taken; bursts and gaps come here.
    task automatic send_item(input logic [7:0] b, input logic eot);
        ulr_pkg::ulr_in_t d;
        int unsigned      gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        d.in_byte = b;
        d.end_of_text = eot;
        s_valid <= 1'b1;
        s_data <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(d);
        @(negedge aclk);
    endtask

    // Sends one character: mostly well formed, some cut short and broken, some noise.
    task automatic send_char(output int unsigned n);
        logic [7:0]  seq[$];
        logic [7:0]  lead;
        logic [7:0]  lo;
        logic [7:0]  hi;
        int unsigned kind;
        int unsigned len;
        int unsigned cut;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            seq = {seq, 8'($urandom_range(0, 255))};
        end else begin
            len = $urandom_range(1, 4);
            case (len)
                1: lead = 8'($urandom_range(0, ulr_pkg::AsciiTop));
                2: lead = 8'($urandom_range(ulr_pkg::Lead2Lo, ulr_pkg::Lead2Hi));
                3: lead = 8'($urandom_range(ulr_pkg::Lead3Lo, ulr_pkg::Lead3Hi));
                default: lead = 8'($urandom_range(ulr_pkg::Lead4Lo, ulr_pkg::Lead4Hi));
            endcase
            seq = {seq, lead};
            lo = ulr_pkg::ContLo;
            hi = ulr_pkg::ContHi;
            if (lead == ulr_pkg::LeadE0) lo = ulr_pkg::ContLoE0;
            if (lead == ulr_pkg::LeadED) hi = ulr_pkg::ContHiED;
            if (lead == ulr_pkg::LeadF0) lo = ulr_pkg::ContLoF0;
            if (lead == ulr_pkg::LeadF4) hi = ulr_pkg::ContHiF4;
            for (int unsigned i = 1; i < len; i++) begin
                seq = {seq, 8'($urandom_range(hi, lo))};
                lo = ulr_pkg::ContLo;
                hi = ulr_pkg::ContHi;
            end
            // Cut the sequence short and follow it with an arbitrary byte.
            if (kind >= 75 && len > 1) begin
                cut = $urandom_range(0, len - 2);
                seq = seq[0:cut];
                seq = {seq, 8'($urandom_range(0, 255))};
            end
        end
        foreach (seq[i]) send_item(seq[i], $urandom_range(0, 19) == 0);
        n = seq.size();
    endtask

    // Sender pause: no transfers until every expected result has come.
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (sb.pending() != 0);
    endtask

    // Main sequence: reset, directed bytes, a pressure phase, then random characters.
    initial begin
        int unsigned n;
        bit          mid_pause_done;
        mid_pause_done = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (DirectedSeq[i]) begin
            send_item(DirectedSeq[i][7:0], DirectedSeq[i][8]);
            directed_n++;
        end
        pause_until_drained();

        // Long receiver hold-off while the sender keeps offering back to back.
        @(posedge aclk);
        hold_req = HoldOffCycles;
        @(negedge aclk);
        burst_left = 40;
        while (random_n < 30) begin
            send_char(n);
            random_n += n;
        end

        while (random_n < RandomItems) begin
            send_char(n);
            random_n += n;
            if (!mid_pause_done && random_n >= RandomItems / 2) begin
                pause_until_drained();
                mid_pause_done = 1;
            end
        end

        pause_until_drained();
        repeat (10) @(posedge aclk);
        if (sb.pending() != 0) sb.report("expected results left over at the end");
        $display("Run covered %0d input bytes (%0d directed, %0d random), %0d result bytes",
                 directed_n + random_n, directed_n, random_n, sb.results_seen);
        $display("with %0d replacement characters, %0d input stall cycles, %0d-cycle hold-off.",
                 sb.repl_chars, backpressure_cycles, longest_hold);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== utf8_lossy_repair_unit.f =====
sv/ulr_pkg.sv
sv/ulr_decode.sv
sv/ulr_burst.sv
sv/utf8_lossy_repair_unit.sv
tb/tb_utf8_lossy_repair_unit.sv
